@@ src/ludpc_pkg.sv @@
package ludpc_pkg;

  // Data path width of the counter value and the level registers
  localparam int unsigned VALUE_WIDTH = 32;
  localparam int unsigned BAND_WIDTH  = VALUE_WIDTH - 1;

  // Configuration register index
  localparam int unsigned CFG_IDX_W = 3;

  localparam logic [CFG_IDX_W-1:0] REG_START_VALUE      = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_STEP_SIZE        = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] REG_LOW_LIMIT        = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] REG_HIGH_LIMIT       = CFG_IDX_W'(3);
  localparam logic [CFG_IDX_W-1:0] REG_LOW_ALARM_LEVEL  = CFG_IDX_W'(4);
  localparam logic [CFG_IDX_W-1:0] REG_HIGH_ALARM_LEVEL = CFG_IDX_W'(5);
  localparam logic [CFG_IDX_W-1:0] REG_LOW_WARN_BAND    = CFG_IDX_W'(6);
  localparam logic [CFG_IDX_W-1:0] REG_HIGH_WARN_BAND   = CFG_IDX_W'(7);

  // Extremes of the signed value range
  localparam logic signed [VALUE_WIDTH-1:0] VALUE_MAX = {1'b0, {(VALUE_WIDTH-1){1'b1}}};
  localparam logic signed [VALUE_WIDTH-1:0] VALUE_MIN = {1'b1, {(VALUE_WIDTH-1){1'b0}}};

  // Status flags kept between items
  typedef struct packed {
    logic high_alarm;
    logic high_warning;
    logic low_alarm;
    logic low_warning;
    logic at_low_limit;
    logic at_high_limit;
    logic at_start;
  } flags_t;

endpackage

@@ src/limited_up_down_pulse_counter_unit.sv @@
// The result of an accepted item is registered and valid in the next cycle.
// Throughput: one item per cycle unless out_ready_i stalls; add, clamp and level
// compares sit in one combinational pass from input handshake to value/flag regs.
// Reset: asynchronous, active low; value and flags clear, the next item loads the
// start value, and the configuration returns to its default levels.
module limited_up_down_pulse_counter_unit
  import ludpc_pkg::*;
(
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // configuration write channel
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]          cfg_index_i,
  input  logic [VALUE_WIDTH-1:0]        cfg_data_i,
  // input items
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic                          pulse_i,
  input  logic                          count_down_i,
  input  logic                          hold_i,
  input  logic                          clear_i,
  input  logic                          enable_i,
  // result items
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic signed [VALUE_WIDTH-1:0] count_value_o,
  output logic                          enabled_out_o,
  output logic                          at_start_o,
  output logic                          at_high_limit_o,
  output logic                          at_low_limit_o,
  output logic                          low_warning_o,
  output logic                          low_alarm_o,
  output logic                          high_warning_o,
  output logic                          high_alarm_o
);

  localparam int unsigned EXT_W = VALUE_WIDTH + 2;

  // configuration registers
  logic signed [VALUE_WIDTH-1:0] start_value_q, step_size_q;
  logic signed [VALUE_WIDTH-1:0] low_limit_q, high_limit_q;
  logic signed [VALUE_WIDTH-1:0] low_alarm_level_q, high_alarm_level_q;
  logic [BAND_WIDTH-1:0]         low_warn_band_q, high_warn_band_q;

  // counter state; doubles as the result register
  logic signed [VALUE_WIDTH-1:0] value_q, value_d;
  flags_t                        flags_q, flags_d;
  logic                          last_pulse_q;
  logic                          first_q;
  logic                          enabled_q;
  logic                          out_valid_q;

  logic                          in_acc;
  logic                          out_acc;

  logic signed [VALUE_WIDTH-1:0] base_value;
  logic                          count_edge;
  logic signed [EXT_W-1:0]       step_ext;
  logic signed [EXT_W-1:0]       sum_ext;
  logic signed [VALUE_WIDTH-1:0] sat_value;
  logic signed [VALUE_WIDTH-1:0] new_value;
  logic signed [VALUE_WIDTH-1:0] clamp_value;
  logic signed [EXT_W-1:0]       low_warn_thr;
  logic signed [EXT_W-1:0]       high_warn_thr;

  assign cfg_ready_o = 1'b1;
  assign out_acc     = out_valid_q & out_ready_i;
  assign in_ready_o  = ~out_valid_q | out_ready_i;
  assign in_acc      = in_valid_i & in_ready_o;

  // configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_value_q      <= '0;
      step_size_q        <= VALUE_WIDTH'(1);
      low_limit_q        <= VALUE_MIN;
      high_limit_q       <= VALUE_MAX;
      low_alarm_level_q  <= VALUE_MIN;
      high_alarm_level_q <= VALUE_MAX;
      low_warn_band_q    <= '0;
      high_warn_band_q   <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        REG_START_VALUE:      start_value_q      <= cfg_data_i;
        REG_STEP_SIZE:        step_size_q        <= cfg_data_i;
        REG_LOW_LIMIT:        low_limit_q        <= cfg_data_i;
        REG_HIGH_LIMIT:       high_limit_q       <= cfg_data_i;
        REG_LOW_ALARM_LEVEL:  low_alarm_level_q  <= cfg_data_i;
        REG_HIGH_ALARM_LEVEL: high_alarm_level_q <= cfg_data_i;
        REG_LOW_WARN_BAND:    low_warn_band_q    <= cfg_data_i[BAND_WIDTH-1:0];
        REG_HIGH_WARN_BAND:   high_warn_band_q   <= cfg_data_i[BAND_WIDTH-1:0];
        default: ;
      endcase
    end
  end

  // saturating step, applied on a rising pulse edge
  assign base_value = first_q ? start_value_q : value_q;
  assign count_edge = pulse_i & ~last_pulse_q & ~hold_i;
  assign step_ext   = count_down_i ? -EXT_W'(step_size_q) : EXT_W'(step_size_q);
  assign sum_ext    = EXT_W'(base_value) + step_ext;

  always_comb begin
    if (sum_ext > EXT_W'(VALUE_MAX)) begin
      sat_value = VALUE_MAX;
    end else if (sum_ext < EXT_W'(VALUE_MIN)) begin
      sat_value = VALUE_MIN;
    end else begin
      sat_value = sum_ext[VALUE_WIDTH-1:0];
    end
  end

  always_comb begin
    if (clear_i) begin
      new_value = start_value_q;
    end else if (count_edge) begin
      new_value = sat_value;
    end else begin
      new_value = base_value;
    end
  end

  // warning thresholds, exact in the extended width
  assign low_warn_thr  = EXT_W'(low_alarm_level_q) + EXT_W'(low_warn_band_q);
  assign high_warn_thr = EXT_W'(high_alarm_level_q) - EXT_W'(high_warn_band_q);

  // clamp to limits (high first) and evaluate the levels
  always_comb begin
    flags_d          = flags_q;
    flags_d.at_start = (new_value == start_value_q);
    clamp_value      = new_value;
    if (new_value >= high_limit_q) begin
      clamp_value           = high_limit_q;
      flags_d.at_high_limit = 1'b1;
    end else begin
      flags_d.at_high_limit = 1'b0;
      if (new_value <= low_limit_q) begin
        clamp_value          = low_limit_q;
        flags_d.at_low_limit = 1'b1;
      end else begin
        flags_d.at_low_limit = 1'b0;
      end
    end
    if (EXT_W'(clamp_value) < low_warn_thr) begin
      flags_d.low_warning = 1'b1;
      flags_d.low_alarm   = (clamp_value < low_alarm_level_q);
    end else begin
      flags_d.low_warning = 1'b0;
      flags_d.low_alarm   = 1'b0;
      if (EXT_W'(clamp_value) > high_warn_thr) begin
        flags_d.high_warning = 1'b1;
        flags_d.high_alarm   = (clamp_value > high_alarm_level_q);
      end else begin
        flags_d.high_warning = 1'b0;
        flags_d.high_alarm   = 1'b0;
      end
    end
  end

  // a disabled item freezes value and flags, except for the start load
  assign value_d = enable_i ? clamp_value : base_value;

  // state update on each accepted item
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      value_q      <= '0;
      flags_q      <= '0;
      last_pulse_q <= 1'b0;
      first_q      <= 1'b1;
      enabled_q    <= 1'b0;
    end else if (in_acc) begin
      value_q      <= value_d;
      if (enable_i) begin
        flags_q <= flags_d;
      end
      last_pulse_q <= pulse_i;
      first_q      <= 1'b0;
      enabled_q    <= enable_i;
    end
  end

  // result valid flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_acc) begin
      out_valid_q <= 1'b1;
    end else if (out_acc) begin
      out_valid_q <= 1'b0;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign count_value_o   = value_q;
  assign enabled_out_o   = enabled_q;
  assign at_start_o      = flags_q.at_start;
  assign at_high_limit_o = flags_q.at_high_limit;
  assign at_low_limit_o  = flags_q.at_low_limit;
  assign low_warning_o   = flags_q.low_warning;
  assign low_alarm_o     = flags_q.low_alarm;
  assign high_warning_o  = flags_q.high_warning;
  assign high_alarm_o    = flags_q.high_alarm;

`ifndef SYNTH
  // every accepted item shows up as a result on the next cycle
  a_acc_gives_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> out_valid_o)
    else $error("accepted item produced no result");

  // a low alarm is always inside the low warning band
  a_low_alarm_warn: assert property (@(posedge clk_i) disable iff (!rst_ni)
    low_alarm_o |-> low_warning_o)
    else $error("low alarm without low warning");

  // a high alarm is always inside the high warning band
  a_high_alarm_warn: assert property (@(posedge clk_i) disable iff (!rst_ni)
    high_alarm_o |-> high_warning_o)
    else $error("high alarm without high warning");

  // a disabled item after the first one leaves value and flags alone
  a_disabled_freeze: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && !enable_i && !first_q) |=>
      (value_q == $past(value_q)) && (flags_q == $past(flags_q)))
    else $error("disabled item changed counter state");
`endif

endmodule

@@ bench/limited_up_down_pulse_counter_unit_test.sv @@
`timescale 1ns / 1ps

module limited_up_down_pulse_counter_unit_test
  import ludpc_pkg::*;
();

  localparam int CYCLE_LIMIT  = 300000;
  localparam int PHASES       = 10;
  localparam int PHASE_ITEMS  = 115;
  localparam int REPORT_LIMIT = 10;

  // Item codes: {pulse, count_down, hold, clear, enable}
  // Directed run A: first-cycle load while disabled, edges up, hold, clamp, clear, edges down
  localparam bit [0:17][4:0] RUN_A = {
    5'b00000, 5'b10001, 5'b10001, 5'b00001, 5'b10101, 5'b00001,
    5'b10001, 5'b00001, 5'b10001, 5'b00001, 5'b10001, 5'b00011,
    5'b11000, 5'b01001, 5'b11001, 5'b01001, 5'b11001, 5'b11001
  };
  // Directed run B: most negative step, saturation at the top of the range
  localparam bit [0:4][4:0] RUN_B = {5'b10001, 5'b00001, 5'b11001, 5'b01001, 5'b11001};
  // Directed run C: crossed limits
  localparam bit [0:1][4:0] RUN_C = {5'b00011, 5'b10001};

  typedef struct {
    logic signed [VALUE_WIDTH-1:0] count;
    logic                          enabled;
    flags_t                        flags;
  } count_result_t;

  // Tracks the counter state and the register file, holds the pending results
  class count_tracker;
    logic signed [VALUE_WIDTH-1:0] start_val, step_val, low_lim, high_lim;
    logic signed [VALUE_WIDTH-1:0] low_alarm_lvl, high_alarm_lvl;
    logic [BAND_WIDTH-1:0]         low_band, high_band;
    logic signed [VALUE_WIDTH-1:0] value_q;
    bit                            last_pulse_q, first_q;
    flags_t                        flags_q;
    count_result_t                 pending_q[$];
    int                            errors;
    int                            results_seen;

    function new();
      start_val      = '0;
      step_val       = 1;
      low_lim        = VALUE_MIN;
      high_lim       = VALUE_MAX;
      low_alarm_lvl  = VALUE_MIN;
      high_alarm_lvl = VALUE_MAX;
      low_band       = '0;
      high_band      = '0;
      value_q        = '0;
      last_pulse_q   = 1'b0;
      first_q        = 1'b1;
      flags_q        = '0;
      errors         = 0;
      results_seen   = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [VALUE_WIDTH-1:0] data);
      case (idx)
        REG_START_VALUE:      start_val      = data;
        REG_STEP_SIZE:        step_val       = data;
        REG_LOW_LIMIT:        low_lim        = data;
        REG_HIGH_LIMIT:       high_lim       = data;
        REG_LOW_ALARM_LEVEL:  low_alarm_lvl  = data;
        REG_HIGH_ALARM_LEVEL: high_alarm_lvl = data;
        REG_LOW_WARN_BAND:    low_band       = data[BAND_WIDTH-1:0];
        REG_HIGH_WARN_BAND:   high_band      = data[BAND_WIDTH-1:0];
        default: ;
      endcase
    endfunction

    // One scan item; wide arithmetic so saturation and band sums are exact
    function void note_scan(bit pulse_lvl, bit down, bit hold_b, bit clr, bit en);
      longint        v;
      longint        start_l;
      flags_t        f;
      count_result_t r;
      start_l = longint'(start_val);
      if (first_q) value_q = start_val;
      if (en) begin
        v = longint'(value_q);
        f = flags_q;
        if (clr) begin
          v = start_l;
        end else if (pulse_lvl && !last_pulse_q && !hold_b) begin
          v = down ? v - longint'(step_val) : v + longint'(step_val);
          if (v > longint'(VALUE_MAX)) v = longint'(VALUE_MAX);
          else if (v < longint'(VALUE_MIN)) v = longint'(VALUE_MIN);
        end
        f.at_start = (v == start_l);
        // high limit wins when the limits cross; low-limit flag kept on a high hit
        if (v >= longint'(high_lim)) begin
          v = longint'(high_lim);
          f.at_high_limit = 1'b1;
        end else begin
          f.at_high_limit = 1'b0;
          if (v <= longint'(low_lim)) begin
            v = longint'(low_lim);
            f.at_low_limit = 1'b1;
          end else begin
            f.at_low_limit = 1'b0;
          end
        end
        // low side first; high flags are left alone while the low warning is up
        if (v - longint'(low_alarm_lvl) < longint'(low_band)) begin
          f.low_warning = 1'b1;
          f.low_alarm   = (v < longint'(low_alarm_lvl));
        end else begin
          f.low_warning = 1'b0;
          f.low_alarm   = 1'b0;
          if (longint'(high_alarm_lvl) - v < longint'(high_band)) begin
            f.high_warning = 1'b1;
            f.high_alarm   = (v > longint'(high_alarm_lvl));
          end else begin
            f.high_warning = 1'b0;
            f.high_alarm   = 1'b0;
          end
        end
        value_q = v[VALUE_WIDTH-1:0];
        flags_q = f;
      end
      last_pulse_q = pulse_lvl;
      first_q      = 1'b0;
      r.count   = value_q;
      r.enabled = en;
      r.flags   = flags_q;
      pending_q.push_back(r);
    endfunction

    function void check_count(count_result_t got);
      count_result_t want;
      results_seen++;
      if (pending_q.size() == 0) begin
        errors++;
        if (errors <= REPORT_LIMIT)
          $display("result %0d arrived with none pending: value %0d en %b flags %b",
                   results_seen, got.count, got.enabled, got.flags);
        return;
      end
      want = pending_q.pop_front();
      if (got.count !== want.count || got.enabled !== want.enabled ||
          got.flags !== want.flags) begin
        errors++;
        if (errors <= REPORT_LIMIT)
          $display("result %0d: expected value %0d en %b flags %b, got value %0d en %b flags %b",
                   results_seen, want.count, want.enabled, want.flags,
                   got.count, got.enabled, got.flags);
      end
    endfunction
  endclass

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready_o;
  logic [CFG_IDX_W-1:0]   cfg_index = '0;
  logic [VALUE_WIDTH-1:0] cfg_data = '0;
  logic                   in_valid = 1'b0;
  logic                   in_ready_o;
  logic                   pulse = 1'b0;
  logic                   count_down = 1'b0;
  logic                   hold = 1'b0;
  logic                   clear_in = 1'b0;
  logic                   enable = 1'b0;
  logic                   out_valid_o;
  logic                   out_ready = 1'b0;
  logic signed [VALUE_WIDTH-1:0] count_value_o;
  logic                   enabled_out_o, at_start_o, at_high_limit_o, at_low_limit_o;
  logic                   low_warning_o, low_alarm_o, high_warning_o, high_alarm_o;

  bit in_steady  = 1'b0;
  bit out_steady = 1'b0;
  int cycle_count = 0;

  count_tracker tracker = new();

  limited_up_down_pulse_counter_unit dut (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .cfg_valid_i     (cfg_valid),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_index_i     (cfg_index),
    .cfg_data_i      (cfg_data),
    .in_valid_i      (in_valid),
    .in_ready_o      (in_ready_o),
    .pulse_i         (pulse),
    .count_down_i    (count_down),
    .hold_i          (hold),
    .clear_i         (clear_in),
    .enable_i        (enable),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready),
    .count_value_o   (count_value_o),
    .enabled_out_o   (enabled_out_o),
    .at_start_o      (at_start_o),
    .at_high_limit_o (at_high_limit_o),
    .at_low_limit_o  (at_low_limit_o),
    .low_warning_o   (low_warning_o),
    .low_alarm_o     (low_alarm_o),
    .high_warning_o  (high_warning_o),
    .high_alarm_o    (high_alarm_o)
  );

  always #1 clk = ~clk;

  // Run watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  function automatic int span(int lo, int hi);
    return lo + int'($urandom_range(hi - lo));
  endfunction

  // Register write; called at a falling edge, returns at a falling edge
  task automatic write_cfg(logic [CFG_IDX_W-1:0] idx, logic [VALUE_WIDTH-1:0] data);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data  = data;
    do @(posedge clk); while (!cfg_ready_o);
    tracker.write_reg(idx, data);
    @(negedge clk);
  endtask

  task automatic load_cfg(logic [VALUE_WIDTH-1:0] start_v, step_v, low_l, high_l,
                          low_a, high_a, low_b, high_b);
    write_cfg(REG_START_VALUE, start_v);
    write_cfg(REG_STEP_SIZE, step_v);
    write_cfg(REG_LOW_LIMIT, low_l);
    write_cfg(REG_HIGH_LIMIT, high_l);
    write_cfg(REG_LOW_ALARM_LEVEL, low_a);
    write_cfg(REG_HIGH_ALARM_LEVEL, high_a);
    write_cfg(REG_LOW_WARN_BAND, low_b);
    write_cfg(REG_HIGH_WARN_BAND, high_b);
    cfg_valid = 1'b0;
  endtask

  // One scan item, random lead-in gap unless in_steady; valid stays up after acceptance
  task automatic send_scan(bit pulse_lvl, bit down, bit hold_b, bit clr, bit en);
    int gap;
    gap = in_steady ? 0 : $urandom_range(7);
    repeat (gap) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid   = 1'b1;
    pulse      = pulse_lvl;
    count_down = down;
    hold       = hold_b;
    clear_in   = clr;
    enable     = en;
    do @(posedge clk); while (!in_ready_o);
    tracker.note_scan(pulse_lvl, down, hold_b, clr, en);
    @(negedge clk);
  endtask

  task automatic send_code(bit [4:0] code);
    send_scan(code[4], code[3], code[2], code[1], code[0]);
  endtask

  // Let every pending result drain before touching the registers
  task automatic drain();
    in_valid = 1'b0;
    while (tracker.pending_q.size() != 0) @(negedge clk);
    repeat (2) @(negedge clk);
  endtask

  task automatic load_random_cfg(int style);
    case (style)
      // small window around zero: limits, alarms and warnings all reachable
      0: load_cfg(span(-40, 40), span(-9, 9), span(-70, -20), span(20, 70),
                  span(-60, 0), span(0, 60),
                  {1'($urandom_range(1)), 31'(span(0, 25))},
                  {1'($urandom_range(1)), 31'(span(0, 25))});
      // huge steps into saturation, wide random levels and bands
      1: load_cfg($urandom_range(1) ? VALUE_MIN : $urandom,
                  $urandom_range(1) ? VALUE_MAX : VALUE_MIN,
                  VALUE_MIN, VALUE_MAX, $urandom, $urandom, $urandom, $urandom);
      // crossed limits
      2: load_cfg(span(-20, 20), span(1, 5), span(0, 30), span(-30, -1),
                  span(-20, 0), span(0, 20), span(0, 10), span(0, 10));
      default: load_cfg($urandom, $urandom, $urandom, $urandom,
                        $urandom, $urandom, $urandom, $urandom);
    endcase
  endtask

  // Result side: random stall before each item unless out_steady, sampled at the rising edge
  initial begin : result_sink
    int            gap;
    count_result_t got;
    @(posedge rst_n);
    forever begin
      gap = out_steady ? 0 : $urandom_range(7);
      repeat (gap) begin
        out_ready = 1'b0;
        @(negedge clk);
      end
      out_ready = 1'b1;
      do @(posedge clk); while (!out_valid_o);
      got.count                 = count_value_o;
      got.enabled               = enabled_out_o;
      got.flags.at_start        = at_start_o;
      got.flags.at_high_limit   = at_high_limit_o;
      got.flags.at_low_limit    = at_low_limit_o;
      got.flags.low_warning     = low_warning_o;
      got.flags.low_alarm       = low_alarm_o;
      got.flags.high_warning    = high_warning_o;
      got.flags.high_alarm      = high_alarm_o;
      tracker.check_count(got);
      @(negedge clk);
    end
  end

  initial begin : stimulus
    int style;
    int down_pct;
    repeat (10) @(negedge clk);
    rst_n = 1'b1;

    // directed checks
    load_cfg(5, 3, -7, 14, -1, 9, 4, 3);
    for (int i = 0; i < 18; i++) send_code(RUN_A[i]);
    drain();
    load_cfg(0, VALUE_MIN, VALUE_MIN, VALUE_MAX, VALUE_MIN, VALUE_MAX, '1, '1);
    for (int i = 0; i < 5; i++) send_code(RUN_B[i]);
    drain();
    load_cfg(0, VALUE_MAX, 100, -100, -5, 5, 2, 2);
    for (int i = 0; i < 2; i++) send_code(RUN_C[i]);

    // random phases, each under a fresh register setting
    for (int phase = 0; phase < PHASES; phase++) begin
      drain();
      style      = (phase % 2 == 0) ? 0 : 1 + (phase / 2) % 3;
      in_steady  = ($urandom_range(3) == 0);
      out_steady = ($urandom_range(3) == 0);
      down_pct   = 25 * span(1, 3);
      load_random_cfg(style);
      repeat (PHASE_ITEMS)
        send_scan(1'($urandom_range(1)), $urandom_range(99) < down_pct,
                  $urandom_range(7) == 0, $urandom_range(15) == 0,
                  $urandom_range(7) != 0);
    end

    drain();
    repeat (4) @(negedge clk);
    if (tracker.errors == 0 && tracker.pending_q.size() == 0)
      $display("TEST PASSED");
    else
      $display("TEST FAILED");
    $finish;
  end

endmodule
